@@ design/rari_pkg.sv @@
// Shared constants, types and helpers for the ray/rectangle intersection unit.
package rari_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int TEX_BITS  = 16;
    localparam int REM_W     = WORD_BITS;
    localparam int T_Q_W     = REM_W + FRAC_BITS;
    localparam int UV_Q_W    = TEX_BITS + 1;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_AXIS   = 3'd0,
        CFG_PLANE_OFFSET = 3'd1,
        CFG_BOUND_A_LOW  = 3'd2,
        CFG_BOUND_A_HIGH = 3'd3,
        CFG_BOUND_B_LOW  = 3'd4,
        CFG_BOUND_B_HIGH = 3'd5,
        CFG_MATERIAL_TAG = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_XY = 2'd0,
        AXIS_XZ = 2'd1,
        AXIS_YZ = 2'd2
    } t_axis;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word o_x;
        t_word o_y;
        t_word o_z;
        t_word d_x;
        t_word d_y;
        t_word d_z;
        t_word t_lo;
        t_word t_hi;
    } t_ray;

    typedef struct packed {
        logic miss;
        logic neg;
        t_ray ray;
    } t_tpay;

    typedef struct packed {
        logic  miss;
        t_word t;
        t_word o_x;
        t_word o_y;
        t_word o_z;
        t_word d_x;
        t_word d_y;
        t_word d_z;
    } t_mpay;

    typedef struct packed {
        logic                     miss;
        t_word                    t;
        t_word                    o_x;
        t_word                    o_y;
        t_word                    o_z;
        logic signed [PROD_W-1:0] pr_x;
        logic signed [PROD_W-1:0] pr_y;
        logic signed [PROD_W-1:0] pr_z;
    } t_ppay;

    typedef struct packed {
        logic  miss;
        logic  zero_u;
        logic  zero_v;
        t_word t;
        t_word p_x;
        t_word p_y;
        t_word p_z;
    } t_hpay;

    // Clamp a wide signed value into one word.
    function automatic t_word sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return t_word'(hi);
        end else if (v < lo) begin
            return t_word'(lo);
        end
        return t_word'(v);
    endfunction

endpackage

@@ design/rari_div_stage.sv @@
// One restoring-division step per lane, with a registered side payload.
module rari_div_stage #(
    parameter int LANES = 1,
    parameter int DQ_W  = 48,
    parameter int PAY_W = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [LANES-1:0][rari_pkg::REM_W-1:0]  i_rem,
    input  logic [LANES-1:0][DQ_W-1:0]             i_dq,
    input  logic [LANES-1:0][rari_pkg::REM_W-1:0]  i_den,
    input  logic [PAY_W-1:0]                       i_pay,
    output logic                                   o_valid,
    output logic [LANES-1:0][rari_pkg::REM_W-1:0]  o_rem,
    output logic [LANES-1:0][DQ_W-1:0]             o_dq,
    output logic [LANES-1:0][rari_pkg::REM_W-1:0]  o_den,
    output logic [PAY_W-1:0]                       o_pay
);
    import rari_pkg::*;

    logic [LANES-1:0][REM_W:0]   trial;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][REM_W-1:0] n_rem;
    logic [LANES-1:0][DQ_W-1:0]  n_dq;
    logic                        r_valid;
    logic [LANES-1:0][REM_W-1:0] r_rem;
    logic [LANES-1:0][DQ_W-1:0]  r_dq;
    logic [LANES-1:0][REM_W-1:0] r_den;
    logic [PAY_W-1:0]            r_pay;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {i_rem[l], i_dq[l][DQ_W-1]};
            ge[l]    = trial[l] >= {1'b0, i_den[l]};
            n_rem[l] = ge[l] ? REM_W'(trial[l] - {1'b0, i_den[l]}) : trial[l][REM_W-1:0];
            n_dq[l]  = {i_dq[l][DQ_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_den <= i_den;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_den   = r_den;
    assign o_pay   = r_pay;

endmodule

@@ design/ray_axis_rect_intersect_unit.sv @@
// Top level of the ray against axis-aligned rectangle intersection unit.
//
// Usage: rays arrive on the input channel (i_valid / o_stall) and one result
// per ray leaves on the output channel (o_valid / i_stall). A transaction
// completes on a rising edge with valid high and stall low.
// The plane and rectangle are set through the write port (i_cfg_wr_en,
// i_cfg_index, i_cfg_data); write them only while no ray is in flight.
// Each ray passes the capture register, the 48-step restoring divider for t,
// the range-check, product and hit-point registers, the 17-step divider pair for u and v, and the output register.
// Throughput: one ray per cycle while the output is not stalled; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: XY plane at offset 0, unit square bounds, tag 0.
// A miss delivers a result with every field zero.
module ray_axis_rect_intersect_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [31:0]             i_origin_x,
    input  logic signed [31:0]             i_origin_y,
    input  logic signed [31:0]             i_origin_z,
    input  logic signed [31:0]             i_dir_x,
    input  logic signed [31:0]             i_dir_y,
    input  logic signed [31:0]             i_dir_z,
    input  logic signed [31:0]             i_t_lower,
    input  logic signed [31:0]             i_t_upper,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit_flag,
    output logic signed [31:0]             o_hit_t,
    output logic [16:0]                    o_tex_u,
    output logic [16:0]                    o_tex_v,
    output logic signed [31:0]             o_point_x,
    output logic signed [31:0]             o_point_y,
    output logic signed [31:0]             o_point_z,
    output logic [15:0]                    o_hit_material,
    output logic [1:0]                     o_normal_axis,
    input  logic                           i_cfg_wr_en,
    input  logic [rari_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import rari_pkg::*;

    localparam int TPAY_W = $bits(t_tpay);
    localparam int HPAY_W = $bits(t_hpay);

    // Configuration registers
    logic [1:0]  r_plane_axis;
    t_word       r_plane_offset;
    t_word       r_bound_a_low;
    t_word       r_bound_a_high;
    t_word       r_bound_b_low;
    t_word       r_bound_b_high;
    logic [15:0] r_material_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_axis   <= AXIS_XY;
            r_plane_offset <= '0;
            r_bound_a_low  <= '0;
            r_bound_a_high <= t_word'(1 << TEX_BITS);
            r_bound_b_low  <= '0;
            r_bound_b_high <= t_word'(1 << TEX_BITS);
            r_material_tag <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PLANE_AXIS:   r_plane_axis   <= i_cfg_data[1:0];
                CFG_PLANE_OFFSET: r_plane_offset <= i_cfg_data;
                CFG_BOUND_A_LOW:  r_bound_a_low  <= i_cfg_data;
                CFG_BOUND_A_HIGH: r_bound_a_high <= i_cfg_data;
                CFG_BOUND_B_LOW:  r_bound_b_low  <= i_cfg_data;
                CFG_BOUND_B_HIGH: r_bound_b_high <= i_cfg_data;
                CFG_MATERIAL_TAG: r_material_tag <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while a waiting result is stalled
    logic en;
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Capture stage
    logic r_s0_valid;
    t_ray r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= '{o_x: i_origin_x, o_y: i_origin_y, o_z: i_origin_z,
                      d_x: i_dir_x, d_y: i_dir_y, d_z: i_dir_z,
                      t_lo: i_t_lower, t_hi: i_t_upper};
        end
    end

    // Divider set-up: pick the normal axis, take magnitudes of k - o and d
    t_word                  on_sel;
    t_word                  dn_sel;
    logic                   axis_bad;
    logic signed [REM_W:0]  diff;
    logic [REM_W-1:0]       diff_mag;
    logic [REM_W-1:0]       den_mag;
    t_tpay                  t_setup;

    always_comb begin
        on_sel   = r_s0.o_z;
        dn_sel   = r_s0.d_z;
        axis_bad = 1'b0;
        unique case (r_plane_axis)
            AXIS_XY: begin
                on_sel = r_s0.o_z;
                dn_sel = r_s0.d_z;
            end
            AXIS_XZ: begin
                on_sel = r_s0.o_y;
                dn_sel = r_s0.d_y;
            end
            AXIS_YZ: begin
                on_sel = r_s0.o_x;
                dn_sel = r_s0.d_x;
            end
            default: axis_bad = 1'b1;
        endcase
        diff     = (REM_W+1)'(r_plane_offset) - (REM_W+1)'(on_sel);
        diff_mag = diff[REM_W] ? REM_W'(-diff) : diff[REM_W-1:0];
        den_mag  = dn_sel[WORD_BITS-1] ? REM_W'(-dn_sel) : REM_W'(dn_sel);
        t_setup.miss = axis_bad || (dn_sel == '0);
        t_setup.neg  = diff[REM_W] ^ dn_sel[WORD_BITS-1];
        t_setup.ray  = r_s0;
    end

    // Divider chain for t, one quotient bit per stage
    logic                   tv   [0:T_Q_W];
    logic [0:0][REM_W-1:0]  trem [0:T_Q_W];
    logic [0:0][T_Q_W-1:0]  tdq  [0:T_Q_W];
    logic [0:0][REM_W-1:0]  tden [0:T_Q_W];
    logic [TPAY_W-1:0]      tpay [0:T_Q_W];

    assign tv[0]   = r_s0_valid;
    assign trem[0] = '0;
    assign tdq[0]  = {diff_mag, {FRAC_BITS{1'b0}}};
    assign tden[0] = den_mag;
    assign tpay[0] = t_setup;

    for (genvar s = 0; s < T_Q_W; s++) begin : g_tdiv
        rari_div_stage #(
            .LANES (1),
            .DQ_W  (T_Q_W),
            .PAY_W (TPAY_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (tv[s]),
            .i_rem   (trem[s]),
            .i_dq    (tdq[s]),
            .i_den   (tden[s]),
            .i_pay   (tpay[s]),
            .o_valid (tv[s+1]),
            .o_rem   (trem[s+1]),
            .o_dq    (tdq[s+1]),
            .o_den   (tden[s+1]),
            .o_pay   (tpay[s+1])
        );
    end

    // Sign, saturate and range-check t
    t_tpay                  t_done;
    logic signed [SUM_W-1:0] t_full;
    t_word                  t_sat;
    t_mpay                  n_m;
    t_mpay                  r_m;
    logic                   r_m_valid;

    always_comb begin
        t_done = t_tpay'(tpay[T_Q_W]);
        t_full = SUM_W'(tdq[T_Q_W][0]);
        if (t_done.neg) begin
            t_full = -t_full;
        end
        t_sat    = sat_word(t_full);
        n_m.miss = t_done.miss || (t_sat < t_done.ray.t_lo) || (t_sat > t_done.ray.t_hi);
        n_m.t    = t_sat;
        n_m.o_x  = t_done.ray.o_x;
        n_m.o_y  = t_done.ray.o_y;
        n_m.o_z  = t_done.ray.o_z;
        n_m.d_x  = t_done.ray.d_x;
        n_m.d_y  = t_done.ray.d_y;
        n_m.d_z  = t_done.ray.d_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= tv[T_Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m <= n_m;
        end
    end

    // Products t * d, one multiplier per axis
    t_ppay n_p;
    t_ppay r_p;
    logic  r_p_valid;

    always_comb begin
        n_p.miss = r_m.miss;
        n_p.t    = r_m.t;
        n_p.o_x  = r_m.o_x;
        n_p.o_y  = r_m.o_y;
        n_p.o_z  = r_m.o_z;
        n_p.pr_x = PROD_W'($signed(r_m.t)) * PROD_W'($signed(r_m.d_x));
        n_p.pr_y = PROD_W'($signed(r_m.t)) * PROD_W'($signed(r_m.d_y));
        n_p.pr_z = PROD_W'($signed(r_m.t)) * PROD_W'($signed(r_m.d_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // Hit point: origin plus floored product, saturated
    t_hpay n_h;
    t_hpay r_h;
    logic  r_h_valid;

    always_comb begin
        n_h.miss   = r_p.miss;
        n_h.zero_u = 1'b0;
        n_h.zero_v = 1'b0;
        n_h.t      = r_p.t;
        n_h.p_x    = sat_word(SUM_W'($signed(r_p.o_x))
                              + SUM_W'($signed(r_p.pr_x[PROD_W-1:FRAC_BITS])));
        n_h.p_y    = sat_word(SUM_W'($signed(r_p.o_y))
                              + SUM_W'($signed(r_p.pr_y[PROD_W-1:FRAC_BITS])));
        n_h.p_z    = sat_word(SUM_W'($signed(r_p.o_z))
                              + SUM_W'($signed(r_p.pr_z[PROD_W-1:FRAC_BITS])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h <= n_h;
        end
    end

    // Bounds check and set-up of the u/v divider pair
    t_word                 pa;
    t_word                 pb;
    logic signed [REM_W:0] xa;
    logic signed [REM_W:0] xb;
    logic signed [REM_W:0] da;
    logic signed [REM_W:0] db;
    t_hpay                 uv_setup;

    always_comb begin
        pa = r_h.p_x;
        pb = r_h.p_y;
        unique case (r_plane_axis)
            AXIS_XY: begin
                pa = r_h.p_x;
                pb = r_h.p_y;
            end
            AXIS_XZ: begin
                pa = r_h.p_x;
                pb = r_h.p_z;
            end
            AXIS_YZ: begin
                pa = r_h.p_y;
                pb = r_h.p_z;
            end
            default: ;
        endcase
        xa = (REM_W+1)'(pa) - (REM_W+1)'(r_bound_a_low);
        xb = (REM_W+1)'(pb) - (REM_W+1)'(r_bound_b_low);
        da = (REM_W+1)'(r_bound_a_high) - (REM_W+1)'(r_bound_a_low);
        db = (REM_W+1)'(r_bound_b_high) - (REM_W+1)'(r_bound_b_low);
        uv_setup        = r_h;
        uv_setup.miss   = r_h.miss || (pa < r_bound_a_low) || (pa > r_bound_a_high)
                          || (pb < r_bound_b_low) || (pb > r_bound_b_high);
        uv_setup.zero_u = (da[REM_W-1:0] == '0);
        uv_setup.zero_v = (db[REM_W-1:0] == '0);
    end

    logic                   uvv   [0:UV_Q_W];
    logic [1:0][REM_W-1:0]  uvrem [0:UV_Q_W];
    logic [1:0][UV_Q_W-1:0] uvdq  [0:UV_Q_W];
    logic [1:0][REM_W-1:0]  uvden [0:UV_Q_W];
    logic [HPAY_W-1:0]      uvpay [0:UV_Q_W];

    // For a hit the quotient stays below 2^17, since the offset there never exceeds the span
    assign uvv[0]   = r_h_valid;
    assign uvrem[0] = {{1'b0, xb[REM_W-1:1]}, {1'b0, xa[REM_W-1:1]}};
    assign uvdq[0]  = {{xb[0], {TEX_BITS{1'b0}}}, {xa[0], {TEX_BITS{1'b0}}}};
    assign uvden[0] = {db[REM_W-1:0], da[REM_W-1:0]};
    assign uvpay[0] = uv_setup;

    for (genvar s = 0; s < UV_Q_W; s++) begin : g_uvdiv
        rari_div_stage #(
            .LANES (2),
            .DQ_W  (UV_Q_W),
            .PAY_W (HPAY_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (uvv[s]),
            .i_rem   (uvrem[s]),
            .i_dq    (uvdq[s]),
            .i_den   (uvden[s]),
            .i_pay   (uvpay[s]),
            .o_valid (uvv[s+1]),
            .o_rem   (uvrem[s+1]),
            .o_dq    (uvdq[s+1]),
            .o_den   (uvden[s+1]),
            .o_pay   (uvpay[s+1])
        );
    end

    // Output register: zero every field on a miss
    t_hpay       uv_done;
    logic        r_out_hit;
    t_word       r_out_t;
    logic [16:0] r_out_u;
    logic [16:0] r_out_v;
    t_word       r_out_px;
    t_word       r_out_py;
    t_word       r_out_pz;
    logic [15:0] r_out_mat;
    logic [1:0]  r_out_axis;

    assign uv_done = t_hpay'(uvpay[UV_Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= uvv[UV_Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (uv_done.miss) begin
                r_out_hit  <= 1'b0;
                r_out_t    <= '0;
                r_out_u    <= '0;
                r_out_v    <= '0;
                r_out_px   <= '0;
                r_out_py   <= '0;
                r_out_pz   <= '0;
                r_out_mat  <= '0;
                r_out_axis <= '0;
            end else begin
                r_out_hit  <= 1'b1;
                r_out_t    <= uv_done.t;
                r_out_u    <= uv_done.zero_u ? '0 : uvdq[UV_Q_W][0];
                r_out_v    <= uv_done.zero_v ? '0 : uvdq[UV_Q_W][1];
                r_out_px   <= uv_done.p_x;
                r_out_py   <= uv_done.p_y;
                r_out_pz   <= uv_done.p_z;
                r_out_mat  <= r_material_tag;
                r_out_axis <= r_plane_axis;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit_flag     = r_out_hit;
    assign o_hit_t        = r_out_t;
    assign o_tex_u        = r_out_u;
    assign o_tex_v        = r_out_v;
    assign o_point_x      = r_out_px;
    assign o_point_y      = r_out_py;
    assign o_point_z      = r_out_pz;
    assign o_hit_material = r_out_mat;
    assign o_normal_axis  = r_out_axis;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_flag |-> o_hit_t == '0 && o_tex_u == '0 && o_tex_v == '0
            && o_point_x == '0 && o_point_y == '0 && o_point_z == '0
            && o_hit_material == '0 && o_normal_axis == '0)
        else $error("miss result carries non-zero fields");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit_flag |-> o_tex_u <= 17'h10000 && o_tex_v <= 17'h10000)
        else $error("texture coordinate above one");

    a_hit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit_flag |-> o_normal_axis == r_plane_axis)
        else $error("normal axis differs from plane orientation");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_h_valid && !r_s0_valid)
        else $error("valid bits survive reset");
`endif

endmodule
